// ===== sv/voice_sample_mixer_core_assert.svh =====
// assertion macros for the voice sample mixer
`ifndef VOICE_SAMPLE_MIXER_CORE_ASSERT_SVH
`define VOICE_SAMPLE_MIXER_CORE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define VSM_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// implication with the consequent checked in the cycle after the antecedent
`define VSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== sv/vsm_pkg.sv =====
// ----------------------------------------------------------------------------
// vsm_pkg
// shared types and constants of the voice sample mixer
// ----------------------------------------------------------------------------
package vsm_pkg;
  localparam int unsigned Voices      = 16;
  localparam int unsigned SampleDepth = 131072;
  localparam int unsigned VoiceW      = $clog2(Voices);
  localparam int unsigned CntW        = $clog2(Voices + 1);
  localparam int unsigned AddrW       = 17;
  localparam int unsigned LenW        = 18;
  localparam int unsigned GainW       = 16;
  localparam int unsigned DataW       = 16;
  localparam int unsigned MemW        = $clog2(SampleDepth);
  localparam int unsigned AccW        = 34 + CntW;
  localparam logic [GainW:0] UnityGain = 17'd32768;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_PLAY = 2'd1,
    FUNC_TICK = 2'd2,
    FUNC_NOP  = 2'd3
  } func_e;

  // voice record passed along the ring
  typedef struct packed {
    logic             active;
    logic [AddrW-1:0] start;
    logic [LenW-1:0]  length;
    logic [LenW-1:0]  pos;
    logic [GainW-1:0] gain;
  } voice_t;
endpackage

// ===== sv/vsm_cell.sv =====
// ----------------------------------------------------------------------------
// vsm_cell
// one voice slot of the rotating voice ring
// ----------------------------------------------------------------------------
module vsm_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  logic            load_i,
  input  vsm_pkg::voice_t load_val_i,
  input  vsm_pkg::voice_t prev_i,
  output vsm_pkg::voice_t voice_o
);
  import vsm_pkg::*;

  voice_t voice_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_q <= '0;
    end else if (load_i) begin
      voice_q <= load_val_i;
    end else if (shift_i) begin
      voice_q <= prev_i;
    end
  end

  assign voice_o = voice_q;
endmodule

// ===== sv/voice_sample_mixer_core.sv =====
// ----------------------------------------------------------------------------
// voice_sample_mixer_core
// 16-voice sample playback mixer over a 128k-word sample memory
// ----------------------------------------------------------------------------
// requests: load and play requests leave busy low; a play with all voices
//   busy scans the ring for a victim and holds busy while it does
// tick: the states mix, drain1, drain2 and out lead to the result strobe; one
//   voice per cycle rotates through the memory read port and the single multiplier
// a new request is taken only once the mixer is back in idle; the result cannot be stalled
// reset: asynchronous, all voices inactive; the sample memory is not cleared
`include "voice_sample_mixer_core_assert.svh"
module voice_sample_mixer_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  func_i,
  input  logic [vsm_pkg::AddrW-1:0]   mem_addr_i,
  input  logic signed [15:0]          mem_data_i,
  input  logic [vsm_pkg::AddrW-1:0]   play_start_i,
  input  logic [vsm_pkg::LenW-1:0]    play_length_i,
  input  logic [vsm_pkg::GainW-1:0]   play_volume_i,
  output logic                        result_valid_o,
  output logic signed [15:0]          sample_out_o,
  output logic [4:0]                  active_count_o
);
  import vsm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_MIX, ST_DRAIN1, ST_DRAIN2, ST_OUT
  } state_e;

  state_e state_q;
  logic [VoiceW:0] cnt_q;

  // ring of voice cells; cell 0 is the head, data moves from cell i+1 to i,
  // the head wraps to the tail, so after Voices shifts the order is restored
  voice_t ring [Voices];
  voice_t ring_nxt [Voices];
  logic   shift;
  logic   [Voices-1:0] load_en;
  voice_t load_val;

  for (genvar g = 0; g < Voices; g++) begin : g_cell
    vsm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (shift),
      .load_i     (load_en[g]),
      .load_val_i (load_val),
      .prev_i     (ring_nxt[g]),
      .voice_o    (ring[g])
    );
  end

  logic [AddrW-1:0] p_start_q;
  logic [LenW-1:0]  p_len_q;
  logic [GainW-1:0] p_gain_q;
  logic [LenW-1:0]  best_pos_q;
  logic [VoiceW-1:0] best_idx_q;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // lowest inactive voice
  logic              free_found;
  logic [VoiceW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = Voices - 1; i >= 0; i--) begin
      if (!ring[i].active) begin
        free_found = 1'b1;
        free_idx   = VoiceW'(i);
      end
    end
  end

  // volume above unity saturates
  logic [GainW-1:0] sat_gain;
  assign sat_gain = ({1'b0, play_volume_i} > UnityGain) ? GainW'(UnityGain) : play_volume_i;

  // head voice advanced by one sample
  voice_t          head_next;
  logic [LenW-1:0] head_pos_inc;
  assign head_pos_inc = ring[0].pos + 1'b1;
  always_comb begin
    head_next     = ring[0];
    if (ring[0].active) begin
      head_next.pos    = head_pos_inc;
      head_next.active = (head_pos_inc < ring[0].length);
    end
  end

  // neighbor feed; the tail takes the advanced copy of the head
  always_comb begin
    for (int i = 0; i < Voices - 1; i++) ring_nxt[i] = ring[i + 1];
    ring_nxt[Voices-1] = head_next;
  end

  // cell loads: play into a free slot at request time, or into the scanned victim
  always_comb begin
    load_en  = '0;
    load_val = '0;
    load_val.active = 1'b1;
    load_val.pos    = '0;
    if (state_q == ST_IDLE) begin
      load_val.start  = play_start_i;
      load_val.length = play_length_i;
      load_val.gain   = sat_gain;
      if (accept && func_i == FUNC_PLAY && play_length_i != '0 && free_found)
        load_en[free_idx] = 1'b1;
    end else begin
      load_val.start  = p_start_q;
      load_val.length = p_len_q;
      load_val.gain   = p_gain_q;
      if (state_q == ST_SCAN && cnt_q == (VoiceW+1)'(Voices))
        load_en[best_idx_q] = 1'b1;
    end
  end

  // during mix the head is rewritten with its advanced copy at the tail
  assign shift = (state_q == ST_MIX);

  // sample memory, undefined until written
  logic [DataW-1:0] mem [SampleDepth];
  logic [DataW-1:0] rd_q;
  logic [GainW-1:0] g1_q;
  logic             v1_q;
  logic [AddrW:0]   rd_addr;
  assign rd_addr = {1'b0, ring[0].start} + {1'b0, ring[0].pos[AddrW-1:0]}
                 + {ring[0].pos[AddrW], {AddrW{1'b0}}};
  logic rd_oor;
  assign rd_oor = (ring[0].pos[LenW-1]) || (rd_addr >= (AddrW+1)'(SampleDepth));

  always_ff @(posedge clk_i) begin
    if (accept && func_i == FUNC_LOAD && 32'(mem_addr_i) < SampleDepth)
      mem[mem_addr_i[MemW-1:0]] <= mem_data_i;
    rd_q <= mem[rd_addr[MemW-1:0]];
  end

  logic signed [33:0] prod_q;
  logic signed [AccW-1:0] acc_q;
  logic [CntW-1:0]  live_q;
  logic             oor_q;

  // clamp of floor(acc/32768)
  logic signed [AccW-16:0] fl;
  logic signed [15:0]      clamped;
  assign fl = acc_q[AccW-1:15];
  assign clamped = (fl > 32767) ? 16'sd32767 : (fl < -32768) ? -16'sd32768 : fl[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cnt_q          <= '0;
      result_valid_o <= 1'b0;
      v1_q           <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (accept && func_i == FUNC_PLAY && play_length_i != '0 && !free_found)
            state_q <= ST_SCAN;
          if (accept && func_i == FUNC_TICK) begin
            state_q <= ST_MIX;
            v1_q    <= 1'b0;
          end
        end
        ST_SCAN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == (VoiceW+1)'(Voices)) state_q <= ST_IDLE;
        end
        ST_MIX: begin
          v1_q  <= ring[0].active;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == (VoiceW+1)'(Voices - 1)) state_q <= ST_DRAIN1;
        end
        ST_DRAIN1: begin
          v1_q    <= 1'b0;
          state_q <= ST_DRAIN2;
        end
        ST_DRAIN2: state_q <= ST_OUT;
        ST_OUT: begin
          result_valid_o <= 1'b1;
          state_q        <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // victim scan over the stored positions, one cell per cycle
  logic [VoiceW-1:0] scan_idx;
  assign scan_idx = cnt_q[VoiceW-1:0];
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      p_start_q  <= play_start_i;
      p_len_q    <= play_length_i;
      p_gain_q   <= sat_gain;
      best_pos_q <= '0;
      best_idx_q <= '0;
    end else if (state_q == ST_SCAN && cnt_q < (VoiceW+1)'(Voices)) begin
      if (cnt_q == '0 || ring[scan_idx].pos > best_pos_q) begin
        best_pos_q <= ring[scan_idx].pos;
        best_idx_q <= scan_idx;
      end
    end
  end

  // mix datapath: read, multiply, accumulate
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MIX) begin
      oor_q <= rd_oor;
      g1_q  <= ring[0].gain;
    end
    if (state_q == ST_IDLE) begin
      acc_q  <= '0;
      live_q <= '0;
      prod_q <= '0;
    end else begin
      prod_q <= (v1_q && !oor_q)
              ? 34'($signed(rd_q) * $signed({1'b0, g1_q})) : '0;
      acc_q  <= acc_q + AccW'(prod_q);
      if (state_q == ST_MIX && head_next.active)
        live_q <= live_q + 1'b1;
    end
    if (state_q == ST_OUT) begin
      sample_out_o   <= clamped;
      active_count_o <= 5'(live_q);
    end
  end

  `VSM_ASSERT(a_busy_state, state_q != ST_IDLE, busy, "busy low outside idle")
  `VSM_ASSERT_NEXT(a_res_after_out, state_q == ST_OUT, result_valid_o, "missing result")
  `VSM_ASSERT(a_res_idle, result_valid_o, state_q == ST_IDLE, "result outside idle")
endmodule

// ===== tb/sv/voice_sample_mixer_core_tb.sv =====
// ----------------------------------------------------------------------------
// voice_sample_mixer_core_tb
// drives load, play and tick requests into the mixer, predicts every mixed
// sample and voice count in a scoreboard and compares them as they strobe out
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module voice_sample_mixer_core_tb;
  import vsm_pkg::*;

  // mixer prediction and queue of pending tick results
  class mix_scoreboard;
    logic signed [15:0] mem [int];
    logic [AddrW-1:0]   v_start [Voices];
    logic [LenW-1:0]    v_len [Voices];
    logic [LenW-1:0]    v_pos [Voices];
    logic [GainW:0]     v_gain [Voices];
    bit                 v_on [Voices];
    logic signed [15:0] exp_sample [$];
    logic [4:0]         exp_count [$];
    int                 errors;

    function new();
      errors = 0;
      for (int i = 0; i < Voices; i++) begin
        v_on[i] = 0; v_pos[i] = '0; v_len[i] = '0; v_start[i] = '0; v_gain[i] = '0;
      end
    endfunction

    // note one accepted request and update the predicted state
    function void note_request(func_e f, logic [AddrW-1:0] ma, logic signed [15:0] md,
                               logic [AddrW-1:0] ps, logic [LenW-1:0] pl,
                               logic [GainW-1:0] pv);
      int slot;
      longint acc, mixed, s;
      int cnt;
      logic [LenW:0] a;
      case (f)
        FUNC_LOAD: if (ma < SampleDepth) mem[ma] = md;
        FUNC_PLAY: if (pl != 0) begin
          slot = -1;
          for (int i = 0; i < Voices; i++) if (slot < 0 && !v_on[i]) slot = i;
          if (slot < 0) begin
            slot = 0;
            for (int i = 1; i < Voices; i++) if (v_pos[i] > v_pos[slot]) slot = i;
          end
          v_start[slot] = ps; v_len[slot] = pl; v_pos[slot] = '0;
          v_gain[slot] = (pv > UnityGain) ? UnityGain : {1'b0, pv};
          v_on[slot] = 1;
        end
        FUNC_TICK: begin
          acc = 0; cnt = 0;
          for (int i = 0; i < Voices; i++) if (v_on[i]) begin
            a = v_start[i] + v_pos[i];
            s = (a < SampleDepth && mem.exists(int'(a))) ? longint'(mem[int'(a)]) : 0;
            acc += s * longint'(v_gain[i]);
            v_pos[i] = v_pos[i] + 1'b1;
            if (v_pos[i] >= v_len[i]) v_on[i] = 0;
            else cnt++;
          end
          mixed = acc >>> 15;   // arithmetic shift is floor division
          if (mixed > 32767) mixed = 32767;
          if (mixed < -32768) mixed = -32768;
          exp_sample.push_back(mixed[15:0]);
          exp_count.push_back(cnt[4:0]);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic signed [15:0] so, logic [4:0] ac);
      if (exp_sample.size() == 0) begin
        $display("%0t: unexpected result sample %0d count %0d", $time, so, ac);
        errors++;
        return;
      end
      if (so !== exp_sample[0]) begin
        $display("%0t: sample_out expected %0d actual %0d", $time, exp_sample[0], so);
        errors++;
      end
      if (ac !== exp_count[0]) begin
        $display("%0t: active_count expected %0d actual %0d", $time, exp_count[0], ac);
        errors++;
      end
      void'(exp_sample.pop_front());
      void'(exp_count.pop_front());
    endfunction
  endclass

  logic clk_i, rst_ni, start, busy, result_valid_o;
  logic [1:0] func_i;
  logic [AddrW-1:0] mem_addr_i, play_start_i;
  logic signed [15:0] mem_data_i, sample_out_o;
  logic [LenW-1:0] play_length_i;
  logic [GainW-1:0] play_volume_i;
  logic [4:0] active_count_o;

  mix_scoreboard sb;
  int idle_pct;
  int quiet_cycles;
  // contiguous region written from address 0; random plays read within it or at the memory top
  int loaded_lo, loaded_hi;

  voice_sample_mixer_core DUT (.*);

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // result check and watchdog, sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.check_result(sample_out_o, active_count_o);
      if ((start && !busy) || result_valid_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // issue one request, with random idle gaps ahead of it
  task automatic send(func_e f, int ma, int md, int ps, int pl, int pv);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk_i);
    end
    start <= 1; func_i <= f; mem_addr_i <= AddrW'(ma); mem_data_i <= 16'(md);
    play_start_i <= AddrW'(ps); play_length_i <= LenW'(pl); play_volume_i <= GainW'(pv);
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_request(f, mem_addr_i, mem_data_i, play_start_i, play_length_i, play_volume_i);
    @(negedge clk_i);
  endtask

  // play a sound that only touches loaded words (or runs past the memory end)
  task automatic play_random();
    int len, st;
    len = ($urandom_range(9) == 0) ? $urandom_range(131072) : $urandom_range(40);
    if ($urandom_range(15) == 0) st = SampleDepth - 1 - $urandom_range(20);
    else st = $urandom_range(loaded_lo, loaded_hi);
    if (st + len > loaded_hi + 1 && st <= loaded_hi) st = 0;
    if (st + len > loaded_hi + 1 && st <= loaded_hi) len = loaded_hi + 1 - st;
    send(FUNC_PLAY, $urandom, $urandom, st, len, $urandom_range(3) == 0 ? $urandom : $urandom_range(32768));
  endtask

  initial begin
    sb = new();
    idle_pct = 0; quiet_cycles = 0;
    start = 0; func_i = FUNC_NOP; mem_addr_i = '0; mem_data_i = '0;
    play_start_i = '0; play_length_i = '0; play_volume_i = '0;
    rst_ni = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: fill low memory and the top words, so every read is defined
    loaded_lo = 0; loaded_hi = 255;
    for (int a = 0; a < 256; a++)
      send(FUNC_LOAD, a, (a % 3 == 0) ? 32767 : (a % 3 == 1) ? -32768 : $urandom, 0, 0, 0);
    for (int a = SampleDepth - 24; a < SampleDepth; a++)
      send(FUNC_LOAD, a, $urandom, 0, 0, 0);
    send(FUNC_TICK, 0, 0, 0, 0, 0);                 // no voices
    send(FUNC_PLAY, 0, 0, 0, 0, 32768);             // zero length ignored
    send(FUNC_NOP, 5, 7, 0, 8, 100);                // unused code
    send(FUNC_TICK, 0, 0, 0, 0, 0);
    for (int v = 0; v < 17; v++)                    // saturate, then steal a voice
      send(FUNC_PLAY, 0, 0, v * 3, 30, v == 0 ? 16'hffff : 32768);
    send(FUNC_PLAY, 0, 0, SampleDepth - 2, 4, 32768); // reads past the memory end
    repeat (6) send(FUNC_TICK, 0, 0, 0, 0, 0);
    send(FUNC_PLAY, 0, 0, 1, 1, 0);
    repeat (40) send(FUNC_TICK, 0, 0, 0, 0, 0);

    // random phases with shifting idle rate
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 7 : (ph == 1) ? 62 : 0;
      for (int n = 0; n < 400; n++) begin
        case ($urandom_range(9))
          0, 1: begin
            int a;
            a = ($urandom_range(20) == 0) ? $urandom : $urandom_range(2047);
            send(FUNC_LOAD, a, $urandom, $urandom, $urandom, $urandom);
            if (a[16:0] == loaded_hi + 1) loaded_hi++;
          end
          2, 3, 4: play_random();
          5: send(FUNC_NOP, $urandom, $urandom, $urandom, $urandom, $urandom);
          default: send(FUNC_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
        endcase
      end
      // grow the written region contiguously between phases
      for (int k = 0; k < 64; k++) begin
        loaded_hi++;
        send(FUNC_LOAD, loaded_hi, $urandom, 0, 0, 0);
      end
    end
    start <= 0;
    // drain long voices cannot finish; just wait for pending results
    while (sb.exp_sample.size() != 0) @(posedge clk_i);
    repeat (Voices + 8) @(posedge clk_i);
    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule

// ===== voice_sample_mixer_core.f =====
+incdir+sv
sv/vsm_pkg.sv
sv/vsm_cell.sv
sv/voice_sample_mixer_core.sv
tb/sv/voice_sample_mixer_core_tb.sv
